### sv/set_assoc_cache_matrix_lru_top_macros.svh
// ----------------------------------------------------------------------------
// set_assoc_cache_matrix_lru_top_macros.svh
// assertion macros for the set associative cache lookup
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_MATRIX_LRU_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_MATRIX_LRU_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SALRU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("salru assertion failed");
`define SALRU_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("salru assertion failed");
`else
`define SALRU_ASSERT(lbl, clk, rstn, prop)
`define SALRU_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

### sv/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// shared types and constants of the set associative cache lookup
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int DefWays       = 4;
  localparam int DefMaxSetBits = 8;
  localparam int DefAddrBits   = 24;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CFG_OFFSET_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SET_WIDTH    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WAYS_IN_USE  = 2'd2;

  localparam logic [4:0] RST_OFFSET_WIDTH = 5'd7;
  localparam logic [3:0] RST_SET_WIDTH    = 4'd3;
  localparam logic [2:0] RST_WAYS_IN_USE  = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

### sv/set_assoc_cache_matrix_lru_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_matrix_lru_top
// set associative cache lookup with bit matrix lru replacement
//
// Each address is split into offset, set index and tag by the configured
// widths; the tags of the set are compared in parallel and the set's lru
// matrix is updated, reporting hit, way and eviction. A transaction first
// reads the set's tag row and state row (valid bits and lru matrix) from
// their rams, then compares, picks the way and writes both rows back; the
// write back waits while a stalled result holds the output register. The
// next address is taken once the write back is done, so a result can wait
// in the output register while the next lookup runs. After reset the state
// ram is cleared one row per cycle, 2**MAX_SET_BITS rows (256 by default),
// before the first address is taken; configuration writes are always taken.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_matrix_lru_top_macros.svh"

module set_assoc_cache_matrix_lru_top #(
  parameter int WAYS         = salru_pkg::DefWays,
  parameter int MAX_SET_BITS = salru_pkg::DefMaxSetBits,
  parameter int ADDR_BITS    = salru_pkg::DefAddrBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [salru_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [salru_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ADDR_BITS-1:0]         address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [1:0]                   way_o,
  output logic                         evicted_o
);

  localparam int NumSets = 1 << MAX_SET_BITS;
  localparam int SetIw   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SelW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW      = $clog2(WAYS + 1);
  localparam int OffW    = $clog2(ADDR_BITS + 1);
  localparam int XW      = ADDR_BITS + 16;
  localparam int TagRowW = WAYS * ADDR_BITS;
  localparam int StRowW  = WAYS + WAYS * WAYS;

  // configuration registers
  logic [4:0] offset_width_q;
  logic [3:0] set_width_q;
  logic [2:0] ways_in_use_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_width_q <= salru_pkg::RST_OFFSET_WIDTH;
      set_width_q    <= salru_pkg::RST_SET_WIDTH;
      ways_in_use_q  <= salru_pkg::RST_WAYS_IN_USE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        salru_pkg::CFG_OFFSET_WIDTH: offset_width_q <= cfg_data_i;
        salru_pkg::CFG_SET_WIDTH:    set_width_q    <= cfg_data_i[3:0];
        salru_pkg::CFG_WAYS_IN_USE:  ways_in_use_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // effective field widths
  logic [OffW-1:0] off_eff;
  logic [3:0]      sw_eff;
  logic [NW-1:0]   n_eff;

  always_comb begin
    off_eff = (32'(offset_width_q) > ADDR_BITS) ? OffW'(ADDR_BITS) : OffW'(offset_width_q);
    sw_eff  = (32'(set_width_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_width_q;
    if (ways_in_use_q == 3'd0) begin
      n_eff = NW'(1);
    end else if (32'(ways_in_use_q) > WAYS) begin
      n_eff = NW'(WAYS);
    end else begin
      n_eff = NW'(ways_in_use_q);
    end
  end

  // address split
  logic [XW-1:0]        addr_x;
  logic [XW-1:0]        set_x;
  logic [XW-1:0]        tag_x;
  logic [OffW:0]        tag_sh;
  logic [SetIw-1:0]     in_set;
  logic [ADDR_BITS-1:0] in_tag;

  always_comb begin
    addr_x = XW'(address_i);
    set_x  = (addr_x >> off_eff) & ~({XW{1'b1}} << sw_eff);
    tag_sh = (OffW + 1)'(off_eff) + (OffW + 1)'(sw_eff);
    tag_x  = addr_x >> tag_sh;
    in_set = set_x[SetIw-1:0];
    in_tag = tag_x[ADDR_BITS-1:0];
  end

  // control
  salru_pkg::state_e state_q, state_d;
  logic [SetIw-1:0]     clr_q, clr_d;
  logic [SetIw-1:0]     set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic                 accept;
  logic                 lookup_done;
  logic                 clr_last;

  assign clr_last = (clr_q == SetIw'(NumSets - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      salru_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = salru_pkg::ST_IDLE;
        end
      end
      salru_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = salru_pkg::ST_LOOKUP;
        end
      end
      salru_pkg::ST_LOOKUP: begin
        if (!out_valid_o || !out_stall_i) begin
          state_d = salru_pkg::ST_IDLE;
        end
      end
      default: state_d = salru_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != salru_pkg::ST_IDLE);
    accept      = in_valid_i && (state_q == salru_pkg::ST_IDLE);
    lookup_done = (state_q == salru_pkg::ST_LOOKUP) && (!out_valid_o || !out_stall_i);
    clr_d       = (state_q == salru_pkg::ST_CLEAR) ? clr_q + SetIw'(1) : clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= salru_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= in_set;
      tag_q <= in_tag;
    end
  end

  // rams
  logic [TagRowW-1:0] tag_rd, tag_wr;
  logic [StRowW-1:0]  st_rd, st_wr, st_wdata;
  logic [SetIw-1:0]   ram_addr;
  logic               st_we;

  always_comb begin
    ram_addr = accept ? in_set : set_q;
    st_we    = lookup_done;
    st_wdata = st_wr;
    if (state_q == salru_pkg::ST_CLEAR) begin
      ram_addr = clr_q;
      st_we    = 1'b1;
      st_wdata = '0;
    end
  end

  salru_ram #(
    .Width (TagRowW),
    .Depth (NumSets)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (lookup_done),
    .re_i    (accept),
    .addr_i  (ram_addr),
    .wdata_i (tag_wr),
    .rdata_o (tag_rd)
  );

  salru_ram #(
    .Width (StRowW),
    .Depth (NumSets)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .re_i    (accept),
    .addr_i  (ram_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rd)
  );

  // compare, replacement choice and update
  logic [WAYS-1:0]      valid_rd;
  logic [WAYS*WAYS-1:0] mat_rd, mat_wr;
  logic [WAYS-1:0]      in_use;
  logic [WAYS-1:0]      row_v [WAYS];
  logic [WAYS-1:0]      best;
  logic                 hit, free;
  logic [SelW-1:0]      hit_sel, free_sel, vic_sel, sel;

  always_comb begin
    valid_rd = st_rd[WAYS-1:0];
    mat_rd   = st_rd[StRowW-1:WAYS];
    hit      = 1'b0;
    free     = 1'b0;
    hit_sel  = '0;
    free_sel = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      in_use[w] = (w < int'(n_eff));
      if (in_use[w] && valid_rd[w] && (tag_rd[w*ADDR_BITS +: ADDR_BITS] == tag_q)) begin
        hit     = 1'b1;
        hit_sel = SelW'(w);
      end
      if (in_use[w] && !valid_rd[w]) begin
        free     = 1'b1;
        free_sel = SelW'(w);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      for (int j = 0; j < WAYS; j++) begin
        row_v[i][WAYS-1-j] = (j < int'(n_eff)) ? mat_rd[i*WAYS+j] : 1'b0;
      end
    end
    vic_sel = '0;
    best    = row_v[0];
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (row_v[w] < best)) begin
        best    = row_v[w];
        vic_sel = SelW'(w);
      end
    end
    sel = hit ? hit_sel : (free ? free_sel : vic_sel);

    mat_wr = mat_rd;
    for (int i = 0; i < WAYS; i++) begin
      for (int j = 0; j < WAYS; j++) begin
        if (SelW'(i) == sel) begin
          mat_wr[i*WAYS+j] = 1'b1;
        end
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      for (int j = 0; j < WAYS; j++) begin
        if (SelW'(j) == sel) begin
          mat_wr[i*WAYS+j] = 1'b0;
        end
      end
    end

    tag_wr = tag_rd;
    st_wr  = {mat_wr, valid_rd};
    for (int w = 0; w < WAYS; w++) begin
      if (SelW'(w) == sel) begin
        st_wr[w] = 1'b1;
        if (!hit) begin
          tag_wr[w*ADDR_BITS +: ADDR_BITS] = tag_q;
        end
      end
    end
  end

  // output register
  logic       out_valid_q;
  logic       hit_q, evicted_q;
  logic [1:0] way_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lookup_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_done) begin
      hit_q     <= hit;
      way_q     <= 2'(sel);
      evicted_q <= !hit && !free;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_o       = way_q;
  assign evicted_o   = evicted_q;

  `SALRU_ASSERT_NEXT(a_done_gives_result, clk_i, rst_ni, lookup_done, out_valid_o)
  `SALRU_ASSERT_NEXT(a_stalled_lookup_waits, clk_i, rst_ni,
                     (state_q == salru_pkg::ST_LOOKUP) && out_valid_o && out_stall_i,
                     state_q == salru_pkg::ST_LOOKUP)
  `SALRU_ASSERT(a_hit_never_evicts, clk_i, rst_ni, !(out_valid_o && hit_o && evicted_o))
  `SALRU_ASSERT(a_state_write_not_idle, clk_i, rst_ni,
                !(st_we && (state_q == salru_pkg::ST_IDLE)))

endmodule

### sv/salru_ram.sv
// ----------------------------------------------------------------------------
// salru_ram
// single port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/tb_set_assoc_cache_matrix_lru_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_matrix_lru_top
// self-checking bench for the set associative cache lookup with lru matrix
//
// Keeps its own copy of the tag store, valid bits, per-set recency matrices
// and field widths, and works out hit, way and eviction for every address
// the block takes. Results are checked in order, field by field. Directed
// lookups cover fills, hits, eviction, width and way clamping, an ignored
// register index and duplicate tags after a way change. Random phases then
// run under a range of settings with addresses built from small tag and set
// pools so that hits and evictions are frequent. Both sides idle at random,
// except during one phase that runs at full rate.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_matrix_lru_top;
  import salru_pkg::*;

  localparam int NumWays       = DefWays;
  localparam int MaxSetBits    = DefMaxSetBits;
  localparam int AddrBits      = DefAddrBits;
  localparam int NumSets       = 1 << MaxSetBits;
  localparam int IdlePct       = 26;
  localparam int WatchLimit    = 4000;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 165;
  localparam int FullRatePhase = 2;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [1:0] way;
    logic       evicted;
  } lookup_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [AddrBits-1:0] address_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                hit_o;
  logic [1:0]          way_o;
  logic                evicted_o;

  logic [AddrBits-1:0]      tag_copy     [NumSets*NumWays];
  bit                       valid_copy   [NumSets*NumWays];
  bit [NumWays*NumWays-1:0] recency_rows [NumSets];
  logic [4:0] offset_reg = RST_OFFSET_WIDTH;
  logic [3:0] set_reg    = RST_SET_WIDTH;
  logic [2:0] ways_reg   = RST_WAYS_IN_USE;

  lookup_t pending_lookups[$];
  int      mismatch_count = 0;
  int      quiet_cycles   = 0;
  bit      no_idle        = 1'b0;

  int phase_offset[NumPhases] = '{7, 0, 4, 2, 23, 10, 5, 3, 24, 31};
  int phase_sets  [NumPhases] = '{3, 0, 8, 2, 0, 15, 1, 4, 0, 6};
  int phase_ways  [NumPhases] = '{4, 1, 4, 3, 2, 4, 0, 7, 4, 5};

  set_assoc_cache_matrix_lru_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .address_i   (address_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .way_o       (way_o),
    .evicted_o   (evicted_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int eff_offset();
    return (offset_reg > AddrBits) ? AddrBits : int'(offset_reg);
  endfunction

  function automatic int eff_set_bits();
    return (set_reg > MaxSetBits) ? MaxSetBits : int'(set_reg);
  endfunction

  function automatic int eff_ways();
    if (ways_reg == 3'd0) begin
      return 1;
    end
    return (ways_reg > NumWays) ? NumWays : int'(ways_reg);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic predict_lookup(input logic [AddrBits-1:0] addr);
    int off, sw, n, set_idx, base, sel, i, j;
    logic [31:0] tag, row, best_row;
    bit [NumWays*NumWays-1:0] m;
    lookup_t r;
    off = eff_offset();
    sw = eff_set_bits();
    n = eff_ways();
    set_idx = int'((32'(addr) >> off) & ((32'd1 << sw) - 32'd1));
    tag = 32'(addr) >> (off + sw);
    base = set_idx * NumWays;
    m = recency_rows[set_idx];
    r = '0;
    sel = 0;
    best_row = '0;
    for (i = 0; i < n; i++) begin
      if (!r.hit && valid_copy[base+i] && tag_copy[base+i] == tag[AddrBits-1:0]) begin
        r.hit = 1'b1;
        sel = i;
      end
    end
    if (!r.hit) begin
      sel = -1;
      for (i = 0; i < n; i++) begin
        if (sel < 0 && !valid_copy[base+i]) begin
          sel = i;
        end
      end
      if (sel < 0) begin
        r.evicted = 1'b1;
        for (i = 0; i < n; i++) begin
          row = '0;
          for (j = 0; j < n; j++) begin
            row = (row << 1) | 32'(m[i*NumWays+j]);
          end
          if (i == 0 || row < best_row) begin
            best_row = row;
            sel = i;
          end
        end
      end
      tag_copy[base+sel] = tag[AddrBits-1:0];
      valid_copy[base+sel] = 1'b1;
    end
    for (j = 0; j < NumWays; j++) begin
      m[sel*NumWays+j] = 1'b1;
    end
    for (j = 0; j < NumWays; j++) begin
      m[j*NumWays+sel] = 1'b0;
    end
    recency_rows[set_idx] = m;
    r.way = sel[1:0];
    pending_lookups.push_back(r);
  endtask

  // register writes, accepted addresses and checked results
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_OFFSET_WIDTH: offset_reg = cfg_data_i;
          CFG_SET_WIDTH:    set_reg = cfg_data_i[3:0];
          CFG_WAYS_IN_USE:  ways_reg = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        predict_lookup(address_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("result transaction with none expected");
        end else begin
          want = pending_lookups.pop_front();
          if (hit_o !== want.hit) begin
            report_mismatch($sformatf("hit got %b expected %b", hit_o, want.hit));
          end
          if (way_o !== want.way) begin
            report_mismatch($sformatf("way got %0d expected %0d", way_o, want.way));
          end
          if (evicted_o !== want.evicted) begin
            report_mismatch($sformatf("evicted got %b expected %b", evicted_o, want.evicted));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchLimit) begin
      $display("timeout: no transaction for %0d cycles", WatchLimit);
      $display("** set_assoc_cache_matrix_lru_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_address(input logic [AddrBits-1:0] addr);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int off, input int sw, input int ways);
    write_register(CFG_OFFSET_WIDTH, CfgDataW'(off));
    write_register(CFG_SET_WIDTH, CfgDataW'(sw));
    write_register(CFG_WAYS_IN_USE, CfgDataW'(ways));
  endtask

  function automatic logic [AddrBits-1:0] compose_address(input logic [31:0] tag,
                                                         input int set_idx);
    int off, sw;
    logic [31:0] a;
    off = eff_offset();
    sw = eff_set_bits();
    a = (tag << (off + sw)) | (32'(set_idx) << off) | ($urandom & ((32'd1 << off) - 32'd1));
    return a[AddrBits-1:0];
  endfunction

  // reset widths: offset 7, set 3, four ways
  task automatic test_basic_lookup();
    send_address(24'h000000);
    send_address(24'hFFFFFF);
    send_address(24'h000000);
    send_address(24'h00007F);
    send_address(24'h000400);
    send_address(24'h000800);
    send_address(24'h000C00);
    send_address(24'h001000);
    send_address(24'h000400);
  endtask

  task automatic test_register_extremes();
    wait_drained();
    apply_settings(0, 0, 1);
    send_address(24'hABCDEF);
    send_address(24'hABCDEF);
    send_address(24'h123456);
    wait_drained();
    // offset beyond the address, set width and ways clamped
    apply_settings(31, 31, 0);
    send_address(24'hFFFFFF);
    send_address(24'h000001);
    wait_drained();
    apply_settings(23, 8, 7);
    send_address(24'h800000);
    wait_drained();
    write_register(CFG_UNUSED, 5'h1F);
    send_address(24'h7FFFFF);
  endtask

  // two ways end up holding the same tag, lowest one must hit
  task automatic test_duplicate_tags();
    wait_drained();
    apply_settings(0, 8, 2);
    send_address(24'h0001A5);
    send_address(24'h0002A5);
    wait_drained();
    write_register(CFG_WAYS_IN_USE, 5'd1);
    send_address(24'h0002A5);
    wait_drained();
    write_register(CFG_WAYS_IN_USE, 5'd2);
    send_address(24'h0002A5);
  endtask

  task automatic test_random_lookups();
    int p, k, n_tags;
    logic [31:0] tag_pool[6];
    int set_pool[3];
    logic [AddrBits-1:0] addr;
    for (p = 0; p < NumPhases; p++) begin
      wait_drained();
      apply_settings(phase_offset[p], phase_sets[p], phase_ways[p]);
      no_idle = (p == FullRatePhase);
      for (k = 0; k < 6; k++) begin
        tag_pool[k] = $urandom;
      end
      for (k = 0; k < 3; k++) begin
        set_pool[k] = $urandom_range((1 << eff_set_bits()) - 1);
      end
      n_tags = eff_ways() + 2;
      for (k = 0; k < ItemsPerPhase; k++) begin
        if ($urandom_range(99) < 80) begin
          addr = compose_address(tag_pool[$urandom_range(n_tags - 1)],
                                 set_pool[$urandom_range(2)]);
        end else begin
          addr = AddrBits'($urandom);
        end
        send_address(addr);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_lookup();
    test_register_extremes();
    test_duplicate_tags();
    test_random_lookups();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("** set_assoc_cache_matrix_lru_top: PASSED **");
    end else begin
      $display("** set_assoc_cache_matrix_lru_top: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/salru_pkg.sv
sv/salru_ram.sv
sv/set_assoc_cache_matrix_lru_top.sv
tb/sv/tb_set_assoc_cache_matrix_lru_top.sv
